@@ rtl/core/sdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo package
// Shared types, register indexes and defaults for the DP disparity block.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int C_MAX_WIDTH      = 512;
    localparam int C_DISPARITY_SPAN = 32;

    localparam logic [7:0] C_THRESH_RST   = 8'd10;
    localparam logic [4:0] C_MIN_DISP_RST = 5'd0;
    localparam logic [4:0] C_MAX_DISP_RST = 5'd31;

    // Configuration register indexes.
    localparam logic [1:0] REG_THRESH   = 2'd0;
    localparam logic [1:0] REG_MIN_DISP = 2'd1;
    localparam logic [1:0] REG_MAX_DISP = 2'd2;

    // Input command codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
        logic       last_column;
        logic [8:0] read_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0] disparity_value;
        logic [8:0] column_index;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_READ,
        CMD_LOAD,
        CMD_START,
        CMD_ROW,
        CMD_CA,
        CMD_CB,
        CMD_CC,
        CMD_BINIT,
        CMD_BL,
        CMD_BTEST,
        CMD_BH,
        CMD_BU,
        CMD_BD
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic busy;
        logic out_free;
        logic row_go;
        logic rows_done;
        logic cell_more;
        logic bt_go;
    } t_stat;

endpackage

@@ rtl/core/sdp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sdp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo controller
// Sequences clearing, loading, reads, table fill and backtrack through the datapath.
// ----------------------------------------------------------------------------
module sdp_ctrl
    import sdp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in,
    input  t_stat    i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_ROW, S_CA, S_CB, S_CC,
        S_BINIT, S_BL, S_BTEST, S_BH, S_BU, S_BD
    } t_state;

    t_state r_state, n_state;
    logic   r_go, n_go;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_go    = r_go;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = r_go ? S_START : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_in.command == OP_READ) begin
                        o_cmd = CMD_READ;
                    end else begin
                        o_cmd = CMD_LOAD;
                        if (!i_stat.busy) begin
                            n_state = S_CLEAR;
                            n_go    = i_in.last_column;
                        end else if (i_in.last_column) begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_START: begin
                o_cmd   = CMD_START;
                n_state = S_ROW;
            end
            S_ROW: begin
                o_cmd = CMD_ROW;
                if (i_stat.rows_done) begin
                    n_state = S_BINIT;
                end else if (i_stat.row_go) begin
                    n_state = S_CA;
                end
            end
            S_CA: begin
                o_cmd   = CMD_CA;
                n_state = S_CB;
            end
            S_CB: begin
                o_cmd   = CMD_CB;
                n_state = S_CC;
            end
            S_CC: begin
                o_cmd   = CMD_CC;
                n_state = i_stat.cell_more ? S_CA : S_ROW;
            end
            S_BINIT: begin
                o_cmd   = CMD_BINIT;
                n_state = S_BL;
            end
            S_BL: begin
                o_cmd   = CMD_BL;
                n_state = S_BTEST;
            end
            S_BTEST: begin
                o_cmd   = CMD_BTEST;
                n_state = i_stat.bt_go ? S_BH : S_IDLE;
            end
            S_BH: begin
                o_cmd   = CMD_BH;
                n_state = S_BU;
            end
            S_BU: begin
                o_cmd   = CMD_BU;
                n_state = S_BD;
            end
            S_BD: begin
                o_cmd   = CMD_BD;
                n_state = S_BTEST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end
endmodule

@@ rtl/core/sdp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo datapath
// Pixel rows, band table, disparity row, counters and the result register.
// ----------------------------------------------------------------------------
module sdp_dp
    import sdp_pkg::*;
#(
    parameter int MAX_WIDTH      = C_MAX_WIDTH,
    parameter int DISPARITY_SPAN = C_DISPARITY_SPAN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    output t_stat     o_stat
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = $clog2(MAX_WIDTH + 66);
    localparam int BD  = MAX_WIDTH * DISPARITY_SPAN;
    localparam int BAW = $clog2(BD);

    // Configuration.
    logic [7:0] r_thresh;
    logic [4:0] r_min_disp, r_max_disp;

    // Control counters and registers.
    logic [CW-1:0] r_len;
    logic          r_busy;
    logic [AW-1:0] r_clr;
    logic [XW-1:0] r_j, r_d, r_m, r_n;
    logic [9:0]    r_l, r_lf, r_diag, r_here, r_up;
    logic [7:0]    r_lp;
    logic          r_vflag;
    logic          r_rd_pend, r_rd_inr;
    logic [8:0]    r_rd_col;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [XW-1:0] w, lo, hi, jd, rr, rc;
    logic [BAW:0]  rd_cell, wr_cell;
    logic [7:0]    left_q, right_q, disp_q, diff, disp_wdata;
    logic [9:0]    band_q, up_v, lf_v, max_v, cell_v, q_v;
    logic          match, disp_we, bt_match;
    logic [AW-1:0] disp_waddr, disp_raddr, pix_waddr;
    logic          pix_we;
    logic [31:0]   col32;

    function automatic logic [BAW:0] f_cell(
        input logic [XW-1:0] r,
        input logic [XW-1:0] c,
        input logic [XW-1:0] wl,
        input logic [XW-1:0] lo_d,
        input logic [XW-1:0] hi_d
    );
        logic [XW-1:0] dd;
        logic          ok;
        logic [31:0]   a;
        dd = c - r;
        ok = (r != '0) && (c != '0) && (r <= wl) && (c <= wl) && (c >= r)
             && (dd >= lo_d) && (dd <= hi_d);
        a  = 32'(r - XW'(1)) * DISPARITY_SPAN + 32'(dd);
        return {ok, a[BAW-1:0]};
    endfunction

    assign w  = XW'(r_len);
    assign lo = XW'(r_min_disp);
    assign hi = (32'(r_max_disp) > DISPARITY_SPAN - 1) ? XW'(DISPARITY_SPAN - 1)
                                                       : XW'(r_max_disp);
    assign jd = r_j + r_d;

    always_comb begin
        rr = r_j;
        rc = jd;
        case (i_cmd)
            CMD_CB:    begin rr = r_j;            rc = jd + XW'(1);     end
            CMD_BINIT: begin rr = w;              rc = w;               end
            CMD_BTEST: begin rr = r_m;            rc = r_n;             end
            CMD_BH:    begin rr = r_m - XW'(1);   rc = r_n;             end
            CMD_BU:    begin rr = r_m;            rc = r_n - XW'(1);    end
            default:   begin rr = r_j;            rc = jd;              end
        endcase
    end

    assign rd_cell = f_cell(rr, rc, w, lo, hi);
    assign wr_cell = f_cell(r_j + XW'(1), jd + XW'(1), w, lo, hi);

    // Cell update: diagonal plus one on a match, else the larger neighbor.
    assign diff   = (r_lp > right_q) ? (r_lp - right_q) : (right_q - r_lp);
    assign match  = diff <= r_thresh;
    assign up_v   = r_vflag ? band_q : 10'd0;
    assign lf_v   = (r_d == lo) ? 10'd0 : r_lf;
    assign max_v  = (up_v > lf_v) ? up_v : lf_v;
    assign cell_v = match ? (r_diag + 10'd1) : max_v;
    assign q_v    = r_vflag ? band_q : 10'd0;

    assign bt_match = !(r_here == r_up) && !(r_here == q_v);

    // Pixel rows.
    assign pix_we    = (i_cmd == CMD_LOAD) && (!r_busy || (32'(r_len) < MAX_WIDTH));
    assign pix_waddr = r_busy ? r_len[AW-1:0] : '0;

    sdp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_left (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(i_in.left_pixel),
        .i_raddr(jd[AW-1:0]), .o_rdata(left_q)
    );
    sdp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_right (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(i_in.right_pixel),
        .i_raddr(r_j[AW-1:0]), .o_rdata(right_q)
    );
    sdp_ram #(.WIDTH(10), .DEPTH(BD)) u_band (
        .i_clk(i_clk), .i_we(i_cmd == CMD_CC), .i_waddr(wr_cell[BAW-1:0]),
        .i_wdata(cell_v), .i_raddr(rd_cell[BAW-1:0]), .o_rdata(band_q)
    );

    // Disparity row: cleared by sweep, written by backtrack, read by commands.
    assign col32      = 32'(i_in.read_column);
    assign disp_raddr = col32[AW-1:0];
    assign disp_we    = (i_cmd == CMD_CLEAR) || ((i_cmd == CMD_BD) && bt_match);
    assign disp_waddr = (i_cmd == CMD_CLEAR) ? r_clr : AW'(r_m - XW'(1));
    assign disp_wdata = (i_cmd == CMD_CLEAR) ? 8'd0 : {5'(r_n - r_m), 3'd0};

    sdp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_disp (
        .i_clk(i_clk), .i_we(disp_we), .i_waddr(disp_waddr), .i_wdata(disp_wdata),
        .i_raddr(disp_raddr), .o_rdata(disp_q)
    );

    assign o_stat.clr_last  = 32'(r_clr) == MAX_WIDTH - 1;
    assign o_stat.busy      = r_busy;
    assign o_stat.out_free  = !r_rd_pend && (!r_out_valid || i_out_ready);
    assign o_stat.row_go    = (lo <= hi) && ((r_j + lo) < w);
    assign o_stat.rows_done = r_j >= w;
    assign o_stat.cell_more = ((r_d + XW'(1)) <= hi) && ((jd + XW'(1)) < w);
    assign o_stat.bt_go     = (r_l != 10'd0) && (r_m != '0) && (r_n != '0);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= C_THRESH_RST;
            r_min_disp  <= C_MIN_DISP_RST;
            r_max_disp  <= C_MAX_DISP_RST;
            r_len       <= '0;
            r_busy      <= 1'b0;
            r_clr       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESH:   r_thresh   <= i_cfg_data;
                    REG_MIN_DISP: r_min_disp <= i_cfg_data[4:0];
                    REG_MAX_DISP: r_max_disp <= i_cfg_data[4:0];
                    default:      ;
                endcase
            end
            r_rd_pend <= i_cmd == CMD_READ;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_CLEAR: r_clr <= r_clr + AW'(1);
                CMD_LOAD: begin
                    if (!r_busy) begin
                        r_len <= CW'(1);
                        r_clr <= '0;
                    end else if (32'(r_len) < MAX_WIDTH) begin
                        r_len <= r_len + CW'(1);
                    end
                    r_busy <= !i_in.last_column;
                end
                default: ;
            endcase
        end
    end

    // Payload and loop registers.
    always_ff @(posedge i_clk) begin
        r_vflag <= rd_cell[BAW];
        if (r_rd_pend) begin
            r_out.disparity_value <= r_rd_inr ? disp_q : 8'd0;
            r_out.column_index    <= r_rd_col;
        end
        case (i_cmd)
            CMD_READ: begin
                r_rd_col <= i_in.read_column;
                r_rd_inr <= col32 < MAX_WIDTH;
            end
            CMD_START: r_j <= '0;
            CMD_ROW: begin
                r_d <= lo;
                if (!(r_j >= w) && !o_stat.row_go) begin
                    r_j <= r_j + XW'(1);
                end
            end
            CMD_CB: begin
                r_lp   <= left_q;
                r_diag <= q_v;
            end
            CMD_CC: begin
                r_lf <= cell_v;
                if (o_stat.cell_more) begin
                    r_d <= r_d + XW'(1);
                end else begin
                    r_j <= r_j + XW'(1);
                end
            end
            CMD_BINIT: begin
                r_m <= w;
                r_n <= w;
            end
            CMD_BL: r_l <= q_v;
            CMD_BH: r_here <= q_v;
            CMD_BU: r_up <= q_v;
            CMD_BD: begin
                if (r_here == r_up) begin
                    r_m <= r_m - XW'(1);
                end else if (r_here == q_v) begin
                    r_n <= r_n - XW'(1);
                end else begin
                    r_l <= r_l - 10'd1;
                    r_m <= r_m - XW'(1);
                    r_n <= r_n - XW'(1);
                end
            end
            default: ;
        endcase
    end

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_out_valid)
        else $error("read data did not reach the result register");

    a_band_write_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_CC) |-> wr_cell[BAW])
        else $error("band table written outside the band");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_WIDTH)
        else $error("row length beyond maximum width");
endmodule

@@ rtl/core/scanline_stereo_dp_disparity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo DP disparity
// Banded LCS matching of one rectified scanline with backtracked disparities.
// ----------------------------------------------------------------------------
// Usage. Items arrive on a valid/ready input channel. A load command carries
// one left/right pixel pair per transfer; the pair flagged last_column closes
// the scanline and starts the table fill. A read command returns one result
// transfer on the output channel with disparity times eight for that column.
// The first load of a scanline is followed by a sweep that clears the
// disparity row before another item is taken; later loads need no sweep.
// After the last pair the fill steps through states CA, CB and CC for each
// band cell and through ROW for each row, as the band table has a single
// read port; each backtrack step then runs through BTEST, BH, BU and BD.
// A read is answered through the result register, from the registered
// read port of the disparity row memory. After reset the same clearing
// sweep runs before any item is taken; configuration writes are taken at
// any time. When the receiver stalls, the result stays in the output
// register and no new item is taken until that slot frees.
// ----------------------------------------------------------------------------
module scanline_stereo_dp_disparity
    import sdp_pkg::*;
#(
    parameter int MAX_WIDTH      = C_MAX_WIDTH,
    parameter int DISPARITY_SPAN = C_DISPARITY_SPAN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    // The controller only sequences; all storage lives in the datapath.
    sdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sdp_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .DISPARITY_SPAN (DISPARITY_SPAN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_stat      (stat)
    );
endmodule

@@ sim/scanline_stereo_dp_disparity_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo DP disparity checker
// Watches the input, output and register ports of the block, keeps its own
// copy of the scanline memories and registers, predicts the answer to every
// read command and compares each output transfer against it.
// ----------------------------------------------------------------------------
module scanline_stereo_dp_disparity_checker
    import sdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int WID  = C_MAX_WIDTH;
    localparam int SPAN = C_DISPARITY_SPAN;

    logic [7:0] thresh;
    logic [4:0] disp_min;
    logic [4:0] disp_max;

    logic [7:0] left_pix  [WID];
    logic [7:0] right_pix [WID];
    logic [7:0] disp_mem  [WID];
    logic [9:0] lcs_band  [WID*SPAN];
    int         line_len;
    bit         loading;

    t_out_item  read_answers[$];

    assign o_pending = read_answers.size();

    // Band cell lookup; anything outside the filled band reads as zero.
    function automatic int band_cell(int r, int c, int w);
        int d;
        if (r == 0 || c == 0 || r > w || c > w || c < r) return 0;
        d = c - r;
        if (d < int'(disp_min) || d > int'(disp_max) || d > SPAN - 1) return 0;
        return int'(lcs_band[(r - 1) * SPAN + d]);
    endfunction

    task automatic match_scanline();
        int w, hi, k, diff, v, up, lf, m, n, l, here;
        w  = line_len;
        hi = (int'(disp_max) > SPAN - 1) ? SPAN - 1 : int'(disp_max);
        for (int j = 0; j < w; j++) begin
            for (int d = int'(disp_min); d <= hi; d++) begin
                k = j + d;
                if (k >= w) break;
                diff = int'(left_pix[k]) - int'(right_pix[j]);
                if (diff < 0) diff = -diff;
                if (diff <= int'(thresh)) begin
                    v = band_cell(j, k, w) + 1;
                end else begin
                    up = band_cell(j, k + 1, w);
                    lf = band_cell(j + 1, k, w);
                    v  = (up > lf) ? up : lf;
                end
                lcs_band[j * SPAN + d] = v[9:0];
            end
        end
        // Walk back from the corner, recording each matched right pixel.
        m = w;
        n = w;
        l = band_cell(w, w, w);
        while (l > 0 && m > 0 && n > 0) begin
            here = band_cell(m, n, w);
            if (here == band_cell(m - 1, n, w)) begin
                m--;
            end else if (here == band_cell(m, n - 1, w)) begin
                n--;
            end else begin
                disp_mem[m - 1] = 8'((n - m) * 8);
                l--;
                m--;
                n--;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            thresh   = C_THRESH_RST;
            disp_min = C_MIN_DISP_RST;
            disp_max = C_MAX_DISP_RST;
            foreach (disp_mem[i]) disp_mem[i] = '0;
            line_len = 0;
            loading  = 0;
            o_fail_count = 0;
            read_answers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (read_answers.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, i_out);
                    o_fail_count++;
                end else begin
                    want = read_answers.pop_front();
                    if (i_out.disparity_value !== want.disparity_value) begin
                        $display("%0t: disparity_value expected %0d actual %0d (column %0d)",
                                 $time, want.disparity_value, i_out.disparity_value,
                                 want.column_index);
                        o_fail_count++;
                    end
                    if (i_out.column_index !== want.column_index) begin
                        $display("%0t: column_index expected %0d actual %0d",
                                 $time, want.column_index, i_out.column_index);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESH:   thresh   = i_cfg_data;
                    REG_MIN_DISP: disp_min = i_cfg_data[4:0];
                    REG_MAX_DISP: disp_max = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.command == OP_READ) begin
                    want.column_index    = i_in.read_column;
                    want.disparity_value = disp_mem[i_in.read_column];
                    read_answers.push_back(want);
                end else begin
                    if (!loading) begin
                        foreach (disp_mem[i]) disp_mem[i] = '0;
                        line_len = 0;
                        loading  = 1;
                    end
                    if (line_len < WID) begin
                        left_pix[line_len]  = i_in.left_pixel;
                        right_pix[line_len] = i_in.right_pixel;
                        line_len++;
                    end
                    if (i_in.last_column) begin
                        match_scanline();
                        loading = 0;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_scanline_stereo_dp_disparity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline stereo DP disparity testbench
// Feeds scanlines with a known shift between the two rows plus noise, mixes
// in reads during and after each load, and sweeps the register settings.
// A checker beside the block predicts every read answer and compares.
// ----------------------------------------------------------------------------
module tb_scanline_stereo_dp_disparity;
    import sdp_pkg::*;

    // The slowest runs are dominated by the table fill of each column plus
    // the clearing sweep of each scanline; this limit leaves a wide margin
    // over that under heavy stalls.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_ITEMS = 130;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int cycles = 0;
    int sent;
    int snd_idle;
    int rcv_stall;
    bit long_hold;

    scanline_stereo_dp_disparity u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    scanline_stereo_dp_disparity_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side. Normally ready drops at random by the stall rate of the
    // phase. When a long hold is requested the receiver refuses transfers
    // for a long stretch so results back up and the input channel stalls.
    initial begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    // Offers one item and returns on the edge where its transfer happens.
    // Valid stays high afterwards so back-to-back items need no gap.
    task automatic offer(t_in_item it);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    task automatic load_pair(int lp, int rp, bit last);
        t_in_item it;
        it.command     = OP_LOAD;
        it.left_pixel  = 8'(lp);
        it.right_pixel = 8'(rp);
        it.last_column = last;
        it.read_column = 9'($urandom_range(511));
        offer(it);
    endtask

    task automatic read_col(int col);
        t_in_item it;
        it.command     = OP_READ;
        it.left_pixel  = 8'($urandom_range(255));
        it.right_pixel = 8'($urandom_range(255));
        it.last_column = 1'($urandom_range(1));
        it.read_column = 9'(col);
        offer(it);
    endtask

    // Register writes go out only when no read answer is outstanding. Each
    // phase ends with reads, so the table fill is finished by then as well.
    task automatic write_regs(int thr, int dmin, int dmax);
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_index <= REG_THRESH;   cfg_data <= 8'(thr);
        @(posedge i_clk);
        cfg_index <= REG_MIN_DISP; cfg_data <= 8'(dmin);
        @(posedge i_clk);
        cfg_index <= REG_MAX_DISP; cfg_data <= 8'(dmax);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One scanline: the right row is the left row shifted by a chosen
    // disparity plus a little noise, with some pixels fully random so the
    // matcher sees both clean runs and occlusions. Reads are sprinkled in
    // while the row loads, then a few follow inside and past the row.
    task automatic run_scanline(int w);
        int shift, lp, rp, noise;
        int lefts[600];
        shift = $urandom_range((w < 31) ? w : 31);
        for (int k = 0; k < w; k++) lefts[k] = $urandom_range(255);
        for (int j = 0; j < w; j++) begin
            if (j + shift < w && $urandom_range(9) != 0) begin
                noise = int'($urandom_range(8)) - 4;
                rp = lefts[j + shift] + noise;
                if (rp < 0) rp = 0;
                if (rp > 255) rp = 255;
            end else begin
                rp = $urandom_range(255);
            end
            lp = lefts[j];
            if ($urandom_range(19) == 0) read_col($urandom_range(511));
            load_pair(lp, rp, j == w - 1);
        end
        repeat ($urandom_range(3, 7)) begin
            if ($urandom_range(3) == 0) read_col($urandom_range(511));
            else read_col($urandom_range(((w < 512) ? w : 512) - 1));
        end
    endtask

    initial begin
        int thr, dmin, dmax, goal, w;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_THRESH;
        cfg_data  = '0;
        sent      = 0;
        snd_idle  = 0;
        rcv_stall = 0;
        long_hold = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings. A read before any scanline,
        // pixel extremes, a read in the middle of a load, reads past the
        // row end and at the top column, then a one-pair and a three-pair scanline.
        read_col(0);
        load_pair(0, 0, 1'b0);
        load_pair(255, 255, 1'b0);
        read_col(511);
        load_pair(255, 0, 1'b0);
        load_pair(0, 255, 1'b1);
        for (int c = 0; c < 4; c++) read_col(c);
        read_col(256);
        read_col(511);
        load_pair(128, 130, 1'b1);
        read_col(0);
        read_col(1);
        load_pair(7, 7, 1'b0);
        load_pair(7, 7, 1'b0);
        load_pair(7, 7, 1'b1);
        read_col(0);
        read_col(2);

        // Random phases, each with its own register settings and idle mix.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin thr = 255; dmin = 0;  dmax = 31; end
                1: begin thr = 0;   dmin = 0;  dmax = 0;  end
                2: begin thr = 10;  dmin = 31; dmax = 31; end
                3: begin thr = 20;  dmin = 20; dmax = 5;  end   // empty band
                default: begin
                    thr  = $urandom_range(0, 40);
                    dmin = $urandom_range(0, 10);
                    dmax = $urandom_range(dmin, 31);
                end
            endcase
            write_regs(thr, dmin, dmax);
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 48; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 48; end
                default: begin snd_idle = 34; rcv_stall = 34; end
            endcase
            goal = sent + PHASE_ITEMS;
            // One oversize scanline shows pairs beyond the row being dropped.
            if (ph == 5) run_scanline(520);
            while (sent < goal) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(40, 64)
                                             : $urandom_range(1, 24);
                if (ph == 2 && sent + 20 > goal && !long_hold) begin
                    // Back up the result side while reads keep coming.
                    long_hold = 1;
                    repeat (12) read_col($urandom_range(511));
                end
                run_scanline(w);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sdp_pkg.sv
rtl/core/sdp_ram.sv
rtl/core/sdp_ctrl.sv
rtl/core/sdp_dp.sv
rtl/core/scanline_stereo_dp_disparity.sv
sim/scanline_stereo_dp_disparity_checker.sv
sim/tb_scanline_stereo_dp_disparity.sv
